FILE: design/wpt_pkg.sv
// Shared types, constants and helpers for the window peak and threshold statistics block.
// No dependencies; used by wpt_div, wpt_seq and the top level.
package wpt_pkg;

  localparam int unsigned CHR_W  = 8;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned SCR_W  = 16;
  localparam int unsigned CNT_W  = 25;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned WS_W   = 25;
  localparam int unsigned CUT_W  = 15;
  localparam int unsigned OCNT_W = 7;
  localparam int unsigned DVD_W  = 42;
  localparam int unsigned DVS_W  = 25;
  localparam int unsigned DSTP_W = 6;

  localparam logic [WS_W-1:0]   WS_RESET  = 25'd100000;
  localparam logic [CUT_W-1:0]  CUT_RESET = 15'd2048;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [OCNT_W-1:0] OUT_CAP   = 7'd64;
  localparam int                MAX_GAP_RESULTS_DEF = 64;

  typedef enum logic {
    REG_WINDOW_SIZE  = 1'b0,
    REG_SCORE_CUTOFF = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [CHR_W-1:0]        chrom;
    logic [POS_W-1:0]        wstart;
    logic [POS_W-1:0]        wend;
    logic                    has;
    logic signed [SCR_W-1:0] score;
    logic [POS_W-1:0]        pos;
    logic [FRAC_W-1:0]       frac;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
  } res_t;

  // Window end: start + w - 1, clamped to a known length and to the last position.
  function automatic logic [POS_W-1:0] calc_win_end(input logic [33:0]      start,
                                                    input logic [WS_W-1:0]  w,
                                                    input logic [POS_W-1:0] len);
    logic [34:0] e;
    e = {1'b0, start} + {10'b0, w} - 35'd1;
    if (len != '0 && e > {3'b0, len}) e = {3'b0, len};
    if (e > 35'h0_FFFF_FFFF) e = 35'h0_FFFF_FFFF;
    return e[POS_W-1:0];
  endfunction

endpackage

FILE: design/wpt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on wpt_pkg for widths and the request/response structs.
module wpt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpt_pkg::div_req_t  req_i,
  output wpt_pkg::div_rsp_t  rsp_o
);

  logic                            busy_q, busy_d;
  logic [wpt_pkg::DSTP_W-1:0]      cnt_q, cnt_d;
  logic [wpt_pkg::DVD_W-1:0]       quo_q, quo_d;
  logic [wpt_pkg::DVS_W-1:0]       rem_q, rem_d;
  logic [wpt_pkg::DVS_W-1:0]       dvs_q, dvs_d;
  logic [wpt_pkg::DVS_W:0]         trial;
  logic [wpt_pkg::DVS_W:0]         diff;
  logic                            ge;

  assign trial = {rem_q, quo_q[wpt_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = wpt_pkg::DSTP_W'(wpt_pkg::DVD_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[wpt_pkg::DVD_W-2:0], ge};
      rem_d = ge ? diff[wpt_pkg::DVS_W-1:0] : trial[wpt_pkg::DVS_W-1:0];
      if (cnt_q == '0) busy_d = 1'b0;
      else cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: design/wpt_seq.sv
// Sequencer and window state: site update, window close, empty-window walk, result hold
// and output register. Depends on wpt_pkg; drives the shared divider wpt_div.
module wpt_seq #(
  parameter int MAX_GAP_RESULTS = wpt_pkg::MAX_GAP_RESULTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [wpt_pkg::WS_W-1:0]          ws_i,
  input  logic [wpt_pkg::CUT_W-1:0]         cut_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [wpt_pkg::CHR_W-1:0]         chrom_id_i,
  input  logic [wpt_pkg::POS_W-1:0]         chrom_length_i,
  input  logic [wpt_pkg::POS_W-1:0]         position_i,
  input  logic signed [wpt_pkg::SCR_W-1:0]  score_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output wpt_pkg::res_t                     res_o,
  output logic                              last_o,
  output wpt_pkg::div_req_t                 div_req_o,
  input  wpt_pkg::div_rsp_t                 div_rsp_i
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_START    = 15'b000000000000010,
    S_CUR      = 15'b000000000000100,
    S_CUR_DIV  = 15'b000000000001000,
    S_TRAIL    = 15'b000000000010000,
    S_TRAIL_DV = 15'b000000000100000,
    S_FLEND    = 15'b000000001000000,
    S_NEWCHR   = 15'b000000010000000,
    S_ADV      = 15'b000000100000000,
    S_ADV_DIV  = 15'b000001000000000,
    S_ADV_GAP  = 15'b000010000000000,
    S_GAP      = 15'b000100000000000,
    S_ADV_SET  = 15'b001000000000000,
    S_UPD      = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_e;

  localparam logic [wpt_pkg::OCNT_W-1:0] MaxGap = wpt_pkg::OCNT_W'(MAX_GAP_RESULTS);

  state_e state_q, state_d, cret_q, cret_d, gret_q, gret_d;
  logic                              seen_q, seen_d;
  logic [wpt_pkg::CHR_W-1:0]         chr_q, chr_d;
  logic [wpt_pkg::POS_W-1:0]         len_q, len_d;
  logic [wpt_pkg::POS_W-1:0]         wfirst_q, wfirst_d, wlast_q, wlast_d;
  logic [wpt_pkg::SCR_W-1:0]         bmag_q, bmag_d;
  logic signed [wpt_pkg::SCR_W-1:0]  bscore_q, bscore_d;
  logic [wpt_pkg::POS_W-1:0]         bpos_q, bpos_d;
  logic [wpt_pkg::CNT_W-1:0]         above_q, above_d, sites_q, sites_d;
  logic                              op_q, op_d;
  logic [wpt_pkg::CHR_W-1:0]         id_q, id_d;
  logic [wpt_pkg::POS_W-1:0]         ilen_q, ilen_d, ipos_q, ipos_d;
  logic signed [wpt_pkg::SCR_W-1:0]  iscore_q, iscore_d;
  logic [wpt_pkg::OCNT_W-1:0]        ocnt_q, ocnt_d;
  logic [33:0]                       gbase_q, gbase_d;
  logic [32:0]                       gcnt_q, gcnt_d;
  logic [wpt_pkg::OCNT_W-1:0]        gbud_q, gbud_d, chgb_q, chgb_d, gj_q, gj_d;
  logic                              gover_q, gover_d;
  logic [wpt_pkg::POS_W-1:0]         glend_q, glend_d, afirst_q, afirst_d;
  logic                              hold_v_q, hold_v_d, out_v_q, out_v_d, last_q, last_d;
  wpt_pkg::res_t                     hold_q, hold_d, out_q, out_d;

  logic [wpt_pkg::WS_W-1:0]          w_eff;
  logic [wpt_pkg::SCR_W-1:0]         mag;
  logic [wpt_pkg::POS_W-1:0]         qpos, nq, e1;
  logic [32:0]                       base;
  logic [wpt_pkg::OCNT_W-1:0]        bud_left;
  logic                              can_emit, em_req;
  wpt_pkg::res_t                     em_res, empty_res;
  logic [1:0]                        reserve;
  logic [wpt_pkg::CNT_W-1:0]         abv_base;
  logic                              first_site;

  assign w_eff    = (ws_i == '0) ? wpt_pkg::WS_W'(1) : ws_i;
  assign mag      = iscore_q[wpt_pkg::SCR_W-1] ? wpt_pkg::SCR_W'(-iscore_q) : iscore_q;
  assign qpos     = (len_q != '0 && ipos_q > len_q) ? len_q : ipos_q;
  assign base     = {1'b0, wlast_q} + 33'd1;
  assign bud_left = (ocnt_q >= MaxGap) ? wpt_pkg::OCNT_W'(1) : MaxGap - ocnt_q;
  assign can_emit = !hold_v_q || !out_v_q || out_ready_i;
  assign first_site = (sites_q == '0);
  assign abv_base   = first_site ? '0 : above_q;

  // Budget for the trailing run on a chromosome change: keep room for the new one's gap.
  assign e1 = wpt_pkg::calc_win_end(34'd1, w_eff, ilen_q);
  assign nq = (ilen_q != '0 && ipos_q > ilen_q) ? ilen_q : ipos_q;
  always_comb begin
    reserve = 2'd0;
    if (nq > e1) reserve = ((nq - e1 - 32'd1) < {7'b0, w_eff}) ? 2'd1 : 2'd2;
  end

  always_comb begin
    empty_res        = '0;
    empty_res.chrom  = chr_q;
    empty_res.wstart = wfirst_q;
    empty_res.wend   = wlast_q;
  end

  always_comb begin
    logic [7:0] b;
    state_d = state_q;  cret_d = cret_q;  gret_d = gret_q;
    seen_d = seen_q;    chr_d = chr_q;    len_d = len_q;
    wfirst_d = wfirst_q; wlast_d = wlast_q;
    bmag_d = bmag_q;    bscore_d = bscore_q; bpos_d = bpos_q;
    above_d = above_q;  sites_d = sites_q;
    op_d = op_q; id_d = id_q; ilen_d = ilen_q; ipos_d = ipos_q; iscore_d = iscore_q;
    ocnt_d = ocnt_q;
    gbase_d = gbase_q; gcnt_d = gcnt_q; gbud_d = gbud_q; chgb_d = chgb_q; gj_d = gj_q;
    gover_d = gover_q; glend_d = glend_q; afirst_d = afirst_q;
    hold_v_d = hold_v_q; hold_d = hold_q;
    out_v_d = out_v_q;  out_d = out_q;   last_d = last_q;
    em_req = 1'b0;
    em_res = empty_res;
    div_req_o = '0;
    div_req_o.divisor = w_eff;
    b = 8'd0;

    if (out_ready_i) out_v_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i; id_d = chrom_id_i; ilen_d = chrom_length_i;
          ipos_d = position_i; iscore_d = score_i;
          ocnt_d = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        if (op_q) begin
          cret_d  = S_TRAIL;
          state_d = seen_q ? S_CUR : S_FIN;
        end else if (!seen_q) begin
          seen_d = 1'b1;
          state_d = S_NEWCHR;
        end else if (id_q != chr_q) begin
          b = 8'(MAX_GAP_RESULTS) - 8'd1 - {6'b0, reserve};
          chgb_d = ($signed(b) < 8'sd1) ? wpt_pkg::OCNT_W'(1) : b[wpt_pkg::OCNT_W-1:0];
          cret_d  = S_TRAIL;
          state_d = S_CUR;
        end else if (qpos <= wlast_q) begin
          state_d = S_UPD;
        end else begin
          state_d = S_ADV;
        end
      end
      S_CUR: begin
        if (first_site) begin
          em_req = 1'b1;
          if (can_emit) begin
            bmag_d = '0; bscore_d = '0; bpos_d = '0; above_d = '0; sites_d = '0;
            state_d = cret_q;
          end
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {above_q, 16'b0} + {17'b0, sites_q >> 1};
          div_req_o.divisor  = sites_q;
          state_d = S_CUR_DIV;
        end
      end
      S_CUR_DIV: begin
        em_res.has   = 1'b1;
        em_res.score = bscore_q;
        em_res.pos   = bpos_q;
        em_res.frac  = div_rsp_i.quot[wpt_pkg::FRAC_W-1:0];
        em_res.cnt   = sites_q;
        if (!div_rsp_i.busy) begin
          em_req = 1'b1;
          if (can_emit) begin
            bmag_d = '0; bscore_d = '0; bpos_d = '0; above_d = '0; sites_d = '0;
            state_d = cret_q;
          end
        end
      end
      S_TRAIL: begin
        gbud_d = op_q ? bud_left : chgb_q;
        gret_d = op_q ? S_FLEND : S_NEWCHR;
        if (len_q != '0 && len_q > wlast_q) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {10'b0, len_q - base[wpt_pkg::POS_W-1:0]};
          state_d = S_TRAIL_DV;
        end else begin
          state_d = op_q ? S_FLEND : S_NEWCHR;
        end
      end
      S_TRAIL_DV: begin
        if (!div_rsp_i.busy) begin
          gbase_d = {1'b0, base};
          gcnt_d  = {1'b0, div_rsp_i.quot[wpt_pkg::POS_W-1:0]} + 33'd1;
          gover_d = ({1'b0, div_rsp_i.quot[wpt_pkg::POS_W-1:0]} + 33'd1) > {26'b0, gbud_q};
          glend_d = wpt_pkg::calc_win_end({2'b0, len_q - {7'b0, div_rsp_i.rem}},
                                          w_eff, len_q);
          gj_d    = '0;
          state_d = S_GAP;
        end
      end
      S_FLEND: begin
        seen_d = 1'b0;
        chr_d = '0; len_d = '0; wfirst_d = 32'd1;
        wlast_d = wpt_pkg::calc_win_end(34'd1, w_eff, '0);
        state_d = S_FIN;
      end
      S_NEWCHR: begin
        chr_d = id_q; len_d = ilen_q; wfirst_d = 32'd1;
        wlast_d = wpt_pkg::calc_win_end(34'd1, w_eff, ilen_q);
        bmag_d = '0; bscore_d = '0; bpos_d = '0; above_d = '0; sites_d = '0;
        state_d = S_ADV;
      end
      S_ADV: begin
        if (qpos <= wlast_q) begin
          state_d = S_UPD;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {10'b0, qpos - base[wpt_pkg::POS_W-1:0]};
          state_d = S_ADV_DIV;
        end
      end
      S_ADV_DIV: begin
        if (!div_rsp_i.busy) begin
          gcnt_d   = {1'b0, div_rsp_i.quot[wpt_pkg::POS_W-1:0]};
          afirst_d = qpos - {7'b0, div_rsp_i.rem};
          cret_d   = S_ADV_GAP;
          state_d  = S_CUR;
        end
      end
      S_ADV_GAP: begin
        gbase_d = {1'b0, base};
        gbud_d  = bud_left;
        gover_d = gcnt_q > {26'b0, bud_left};
        glend_d = wpt_pkg::calc_win_end({2'b0, afirst_q} - {9'b0, w_eff}, w_eff, len_q);
        gj_d    = '0;
        gret_d  = S_ADV_SET;
        state_d = S_GAP;
      end
      S_GAP: begin
        em_res.wstart = gbase_q[wpt_pkg::POS_W-1:0];
        em_res.wend   = wpt_pkg::calc_win_end(gbase_q, w_eff, len_q);
        if (!gover_q && {26'b0, gj_q} == gcnt_q) begin
          state_d = gret_q;
        end else if (gover_q && (gj_q + 7'd1) == gbud_q) begin
          // collapsed tail of a long empty run
          em_res.wend = glend_q;
          em_res.ovf  = 1'b1;
          em_req = 1'b1;
          if (can_emit) state_d = gret_q;
        end else begin
          em_req = 1'b1;
          if (can_emit) begin
            gj_d    = gj_q + 7'd1;
            gbase_d = gbase_q + {9'b0, w_eff};
          end
        end
      end
      S_ADV_SET: begin
        wfirst_d = afirst_q;
        wlast_d  = wpt_pkg::calc_win_end({2'b0, afirst_q}, w_eff, len_q);
        state_d  = S_UPD;
      end
      S_UPD: begin
        if (first_site || mag > bmag_q) begin
          bmag_d = mag; bscore_d = iscore_q; bpos_d = ipos_q;
        end
        above_d = (mag > {1'b0, cut_i} && abv_base != wpt_pkg::CNT_MAX) ?
                  abv_base + 1'b1 : abv_base;
        if (sites_q != wpt_pkg::CNT_MAX) sites_d = sites_q + 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (!out_v_q || out_ready_i) begin
          out_d = hold_q; last_d = 1'b1; out_v_d = 1'b1;
          hold_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Results pass through a one-beat hold so the final one can carry last.
    if (em_req && can_emit && ocnt_q != wpt_pkg::OUT_CAP) begin
      if (hold_v_q) begin
        out_d = hold_q; last_d = 1'b0; out_v_d = 1'b1;
      end
      hold_d   = em_res;
      hold_v_d = 1'b1;
      ocnt_d   = ocnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cret_q <= S_IDLE; gret_q <= S_IDLE;
      seen_q <= 1'b0; chr_q <= '0; len_q <= '0;
      wfirst_q <= 32'd1; wlast_q <= 32'(wpt_pkg::WS_RESET);
      bmag_q <= '0; bscore_q <= '0; bpos_q <= '0; above_q <= '0; sites_q <= '0;
      ocnt_q <= '0; hold_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; cret_q <= cret_d; gret_q <= gret_d;
      seen_q <= seen_d; chr_q <= chr_d; len_q <= len_d;
      wfirst_q <= wfirst_d; wlast_q <= wlast_d;
      bmag_q <= bmag_d; bscore_q <= bscore_d; bpos_q <= bpos_d;
      above_q <= above_d; sites_q <= sites_d;
      ocnt_q <= ocnt_d; hold_v_q <= hold_v_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; ilen_q <= ilen_d; ipos_q <= ipos_d; iscore_q <= iscore_d;
    gbase_q <= gbase_d; gcnt_q <= gcnt_d; gbud_q <= gbud_d; chgb_q <= chgb_d;
    gj_q <= gj_d; gover_q <= gover_d; glend_q <= glend_d; afirst_q <= afirst_d;
    hold_q <= hold_d; out_q <= out_d; last_q <= last_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign res_o       = out_q;
  assign last_o      = last_q;

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_v_q) else $error("result left in hold while idle");

  a_ocnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= wpt_pkg::OUT_CAP) else $error("result count beyond cap");

  a_unseen_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !seen_q) |-> sites_q == '0) else $error("stale sites");

  a_win_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> wfirst_q <= wlast_q) else $error("window start after end");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |=> div_rsp_i.busy) else $error("divider did not start");

endmodule

FILE: design/window_peak_and_threshold_stats_top.sv
// Top level of the window peak and threshold statistics block: config registers and
// instances of wpt_seq and wpt_div. Depends on wpt_pkg.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------------
//   config   | in        | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//   site in  | in        | in_valid_i / in_ready_o    | operation, chrom, length, pos, score
//   result   | out       | out_valid_o / out_ready_i  | window record fields, last_o
//
// A site that stays in the open window passes through accept, decode, update and finish.
// Closing a window with sites runs start, 42 steps of the shared divider and the result.
// Moving past the window end or ending a chromosome of known length runs the divider
// again for the window count, then one empty-window result per cycle unless output stalls.
// Output back-pressure stalls the sequencer.
// Reset is asynchronous and active low; no clearing pass follows it.
module window_peak_and_threshold_stats_top #(
  parameter int MAX_GAP_RESULTS = wpt_pkg::MAX_GAP_RESULTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [wpt_pkg::WS_W-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [wpt_pkg::CHR_W-1:0]         chrom_id_i,
  input  logic [wpt_pkg::POS_W-1:0]         chrom_length_i,
  input  logic [wpt_pkg::POS_W-1:0]         position_i,
  input  logic signed [wpt_pkg::SCR_W-1:0]  score_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wpt_pkg::CHR_W-1:0]         out_chrom_o,
  output logic [wpt_pkg::POS_W-1:0]         win_start_o,
  output logic [wpt_pkg::POS_W-1:0]         win_end_o,
  output logic                              has_sites_o,
  output logic signed [wpt_pkg::SCR_W-1:0]  extreme_score_o,
  output logic [wpt_pkg::POS_W-1:0]         extreme_position_o,
  output logic [wpt_pkg::FRAC_W-1:0]        above_fraction_o,
  output logic [wpt_pkg::CNT_W-1:0]         site_count_o,
  output logic                              gap_overflow_o,
  output logic                              last_o
);

  logic [wpt_pkg::WS_W-1:0]  ws_q;
  logic [wpt_pkg::CUT_W-1:0] cut_q;
  wpt_pkg::res_t             res;
  wpt_pkg::div_req_t         div_req;
  wpt_pkg::div_rsp_t         div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= wpt_pkg::WS_RESET;
      cut_q <= wpt_pkg::CUT_RESET;
    end else if (cfg_we_i) begin
      case (wpt_pkg::reg_idx_e'(cfg_addr_i))
        wpt_pkg::REG_WINDOW_SIZE:  ws_q  <= cfg_wdata_i;
        wpt_pkg::REG_SCORE_CUTOFF: cut_q <= cfg_wdata_i[wpt_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  wpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  wpt_seq #(
    .MAX_GAP_RESULTS(MAX_GAP_RESULTS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ws_i           (ws_q),
    .cut_i          (cut_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .chrom_id_i     (chrom_id_i),
    .chrom_length_i (chrom_length_i),
    .position_i     (position_i),
    .score_i        (score_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .res_o          (res),
    .last_o         (last_o),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp)
  );

  assign out_chrom_o        = res.chrom;
  assign win_start_o        = res.wstart;
  assign win_end_o          = res.wend;
  assign has_sites_o        = res.has;
  assign extreme_score_o    = res.score;
  assign extreme_position_o = res.pos;
  assign above_fraction_o   = res.frac;
  assign site_count_o       = res.cnt;
  assign gap_overflow_o     = res.ovf;

endmodule
